[rtl/swsc_pkg.sv]
// Shared constants, codes and controller/datapath handshake types
// for the sieve window survivor counter. No dependencies.
`default_nettype none

package swsc_pkg;

  // Sizing
  localparam int TABLE_DEPTH = 512;
  localparam int WINDOW      = 10000;

  // Fixed field widths
  localparam int WS_W   = 17;
  localparam int OFS_W  = 8;
  localparam int STEP_W = 9;
  localparam int SURV_W = 14;
  localparam int USED_W = 10;

  localparam int unsigned SURV_MAX = 16383;
  localparam int unsigned USED_MAX = 1023;

  // Derived widths
  localparam int TAB_AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int ENT_W  = $clog2(TABLE_DEPTH + 1);
  localparam int MAP_AW = $clog2(WINDOW);
  localparam int POS_W  = $clog2(WINDOW + 512);
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int DIV_CW = $clog2(WS_W);

  typedef enum logic [1:0] {
    MODE_LOAD    = 2'd0,
    MODE_COMPUTE = 2'd1,
    MODE_CLEAR   = 2'd2
  } swsc_mode_t;

  // Controller -> datapath
  typedef struct packed {
    logic load;
    logic clear;
    logic addr_clear;
    logic fill_step;
    logic scan_start;
    logic fetch;
    logic setup;
    logic div_step;
    logic place;
    logic walk_step;
    logic count_start;
    logic count_step;
    logic result_load;
  } swsc_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic addr_last;
    logic idx_done;
    logic direct;
    logic div_last;
    logic walk_done;
  } swsc_sts_t;

endpackage

`default_nettype wire

[rtl/swsc_in_if.sv]
// Input channel: valid/ready plus one input transaction payload.
// Depends on swsc_pkg.
`default_nettype none

interface swsc_in_if import swsc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic [OFS_W-1:0]  start_offset;
  logic [STEP_W-1:0] step;

  modport source (output valid, output mode, output start_offset, output step, input ready);
  modport sink   (input valid, input mode, input start_offset, input step, output ready);
endinterface

`default_nettype wire

[rtl/swsc_out_if.sv]
// Output channel: valid/ready plus one result transaction payload.
// Depends on swsc_pkg.
`default_nettype none

interface swsc_out_if import swsc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SURV_W-1:0] survivors;
  logic [USED_W-1:0] used_entries;
  logic              overflowed;

  modport source (output valid, output survivors, output used_entries, output overflowed,
                  input ready);
  modport sink   (input valid, input survivors, input used_entries, input overflowed,
                  output ready);
endinterface

`default_nettype wire

[rtl/swsc_ctrl.sv]
// Sequencer for the survivor counter: drives datapath commands.
// Depends on swsc_pkg.
`default_nettype none

module swsc_ctrl import swsc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic [1:0] in_mode,
  output logic      in_ready,
  input  logic      out_ready,
  output logic      out_valid,
  output swsc_cmd_t cmd,
  input  swsc_sts_t sts
);

  typedef enum logic [3:0] {
    S_IDLE, S_FILL, S_SCAN, S_SETUP, S_DIV, S_PLACE, S_WALK, S_COUNT, S_DRAIN, S_RESULT
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          unique case (in_mode)
            MODE_LOAD:  cmd.load  = 1'b1;
            MODE_CLEAR: cmd.clear = 1'b1;
            MODE_COMPUTE: begin
              cmd.addr_clear = 1'b1;
              state_next     = S_FILL;
            end
            default: ;
          endcase
        end
      end
      S_FILL: begin
        cmd.fill_step = 1'b1;
        if (sts.addr_last) begin
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.idx_done) begin
          cmd.count_start = 1'b1;
          state_next      = S_COUNT;
        end else begin
          cmd.fetch  = 1'b1;
          state_next = S_SETUP;
        end
      end
      S_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = sts.direct ? S_WALK : S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) state_next = S_PLACE;
      end
      S_PLACE: begin
        cmd.place  = 1'b1;
        state_next = S_WALK;
      end
      S_WALK: begin
        if (sts.walk_done) state_next = S_SCAN;
        else cmd.walk_step = 1'b1;
      end
      S_COUNT: begin
        cmd.count_step = 1'b1;
        if (sts.addr_last) state_next = S_DRAIN;
      end
      S_DRAIN: state_next = S_RESULT;
      S_RESULT: begin
        if (!out_valid || out_ready) begin
          cmd.result_load = 1'b1;
          state_next      = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.result_load) out_valid <= 1'b1;
    end
  end

endmodule

`default_nettype wire

[rtl/swsc_dpath.sv]
// Datapath: progression table, window bitmap, remainder unit, walk and count.
// Depends on swsc_pkg; commanded by swsc_ctrl.
`default_nettype none

module swsc_dpath import swsc_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [WS_W-1:0]   cfg_wdata,
  input  logic [OFS_W-1:0]  in_start_offset,
  input  logic [STEP_W-1:0] in_step,
  input  swsc_cmd_t         cmd,
  output swsc_sts_t         sts,
  output logic [SURV_W-1:0] survivors,
  output logic [USED_W-1:0] used_entries,
  output logic              overflowed
);

  logic [WS_W-1:0]   window_start;
  logic [ENT_W-1:0]  entry_count;
  logic              overflow_flag;
  logic              has_room;

  logic [OFS_W-1:0]  ofs_mem  [TABLE_DEPTH];
  logic [STEP_W-1:0] step_mem [TABLE_DEPTH];
  logic [OFS_W-1:0]  tab_ofs;
  logic [STEP_W-1:0] tab_step;
  logic [ENT_W-1:0]  idx;

  logic              map_mem [WINDOW];
  logic              map_we;
  logic [MAP_AW-1:0] map_wa;
  logic              map_rd;
  logic              rd_valid;
  logic [MAP_AW-1:0] addr;
  logic [CNT_W-1:0]  acc;

  logic [POS_W-1:0]  pos;
  logic [STEP_W-1:0] rem;
  logic [WS_W-1:0]   gap_sh;
  logic [DIV_CW-1:0] div_cnt;

  logic              ofs_ge;
  logic              step_zero;
  logic [WS_W-1:0]   gap;
  logic [STEP_W:0]   trial;
  logic [STEP_W:0]   trial_diff;
  logic [STEP_W-1:0] rem_next;
  logic [STEP_W-1:0] step_less_rem;
  logic [SURV_W-1:0] surv_sat;
  logic [USED_W-1:0] used_sat;

  assign has_room  = entry_count < ENT_W'(TABLE_DEPTH);
  assign ofs_ge    = WS_W'(tab_ofs) >= window_start;
  assign step_zero = (tab_step == '0);
  assign gap       = window_start - WS_W'(tab_ofs);

  // restoring division step, remainder only
  assign trial      = {rem, gap_sh[WS_W-1]};
  assign trial_diff = trial - {1'b0, tab_step};
  assign rem_next   = (trial >= {1'b0, tab_step}) ? trial_diff[STEP_W-1:0]
                                                  : trial[STEP_W-1:0];
  assign step_less_rem = tab_step - rem;

  assign sts.addr_last = (addr == MAP_AW'(WINDOW - 1));
  assign sts.idx_done  = (idx == entry_count);
  assign sts.direct    = step_zero || ofs_ge;
  assign sts.div_last  = (div_cnt == '0);
  assign sts.walk_done = (pos >= POS_W'(WINDOW));

  always_comb begin
    surv_sat = (32'(acc) > SURV_MAX) ? SURV_W'(SURV_MAX) : SURV_W'(acc);
    used_sat = (32'(entry_count) > USED_MAX) ? USED_W'(USED_MAX) : USED_W'(entry_count);
  end

  // control and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      window_start  <= '0;
      entry_count   <= '0;
      overflow_flag <= 1'b0;
      rd_valid      <= 1'b0;
    end else begin
      if (cfg_we) window_start <= cfg_wdata;
      if (cmd.load) begin
        if (has_room) entry_count <= entry_count + 1'b1;
        else overflow_flag <= 1'b1;
      end
      if (cmd.clear) begin
        entry_count   <= '0;
        overflow_flag <= 1'b0;
      end
      rd_valid <= cmd.count_step;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.addr_clear || cmd.count_start) addr <= '0;
    else if (cmd.fill_step || cmd.count_step) addr <= addr + 1'b1;

    if (cmd.scan_start) idx <= '0;
    else if (cmd.fetch) idx <= idx + 1'b1;

    if (cmd.count_start) acc <= '0;
    else if (rd_valid) acc <= acc + CNT_W'(map_rd);

    if (cmd.setup) begin
      pos     <= ofs_ge ? POS_W'(tab_ofs - window_start[OFS_W-1:0]) : POS_W'(WINDOW);
      rem     <= '0;
      gap_sh  <= gap;
      div_cnt <= DIV_CW'(WS_W - 1);
    end else if (cmd.div_step) begin
      rem     <= rem_next;
      gap_sh  <= {gap_sh[WS_W-2:0], 1'b0};
      div_cnt <= div_cnt - 1'b1;
    end else if (cmd.place) begin
      pos <= (rem == '0) ? '0 : POS_W'(step_less_rem);
    end else if (cmd.walk_step) begin
      pos <= step_zero ? POS_W'(WINDOW) : pos + POS_W'(tab_step);
    end

    if (cmd.result_load) begin
      survivors    <= surv_sat;
      used_entries <= used_sat;
      overflowed   <= overflow_flag;
    end
  end

  // progression table
  always_ff @(posedge clk) begin
    if (cmd.load && has_room) begin
      ofs_mem[entry_count[TAB_AW-1:0]]  <= in_start_offset;
      step_mem[entry_count[TAB_AW-1:0]] <= in_step;
    end
    if (cmd.fetch) begin
      tab_ofs  <= ofs_mem[idx[TAB_AW-1:0]];
      tab_step <= step_mem[idx[TAB_AW-1:0]];
    end
  end

  // window bitmap: fill writes ones, walk writes zeros
  assign map_we = cmd.fill_step || cmd.walk_step;
  assign map_wa = cmd.walk_step ? pos[MAP_AW-1:0] : addr;

  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_wa] <= cmd.fill_step;
    if (cmd.count_step) map_rd <= map_mem[addr];
  end

`ifndef SYNTH
  a_walk_in_window: assert property (@(posedge clk) disable iff (rst)
    cmd.walk_step |-> pos < POS_W'(WINDOW))
    else $error("bitmap strike outside window");

  a_fetch_valid_entry: assert property (@(posedge clk) disable iff (rst)
    cmd.fetch |-> idx < entry_count)
    else $error("table read beyond loaded entries");

  a_rem_below_step: assert property (@(posedge clk) disable iff (rst)
    cmd.place |-> rem < tab_step)
    else $error("remainder not below step");

  a_overflow_sets: assert property (@(posedge clk) disable iff (rst)
    (cmd.load && !has_room && !cmd.clear) |=> overflow_flag)
    else $error("dropped load did not set overflow");
`endif

endmodule

`default_nettype wire

[rtl/sieve_window_survivor_count.sv]
// Load, clear and unused-mode transactions are taken one per cycle while the block is idle;
// a compute holds off the input until its result is loaded. The single-port bitmap sweeps
// (fill, then count) bracket the walk of each progression; a nonzero step that starts below
// window_start first needs a serial remainder (1 bit/cycle).
// Reset (rst, synchronous): empties the table, clears overflow, window_start to 0, no result.
// Top level of the sieve window survivor counter. Depends on swsc_pkg, swsc_in_if,
// swsc_out_if, swsc_ctrl and swsc_dpath.
`default_nettype none

module sieve_window_survivor_count import swsc_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,     // window_start write strobe
  input  logic [WS_W-1:0] cfg_wdata,  // window_start value
  swsc_in_if.sink         in_ch,      // load / compute / clear transactions
  swsc_out_if.source      out_ch      // one result per compute
);

  // Controller and datapath talk only through these two buses.
  swsc_cmd_t cmd;
  swsc_sts_t sts;

  // The sequencer owns the handshakes; a finished result sits in the output
  // register while new loads and clears are still taken.
  swsc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_mode   (in_ch.mode),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Table, bitmap, remainder unit, walker and survivor counter.
  swsc_dpath u_dpath (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .in_start_offset (in_ch.start_offset),
    .in_step         (in_ch.step),
    .cmd             (cmd),
    .sts             (sts),
    .survivors       (out_ch.survivors),
    .used_entries    (out_ch.used_entries),
    .overflowed      (out_ch.overflowed)
  );

endmodule

`default_nettype wire

[verif/swsc_checker.sv]
// Result checker for sieve_window_survivor_count: tracks window, progression table and
// overflow state from the pins, predicts each compute result and compares it field by field.
// Depends on swsc_pkg, swsc_in_if and swsc_out_if.
module swsc_checker import swsc_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_we,
  input  logic [WS_W-1:0] cfg_wdata,
  swsc_in_if              in_ch,
  swsc_out_if             out_ch,
  output int unsigned     failures,
  output int unsigned     pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [SURV_W-1:0] survivors;
    logic [USED_W-1:0] used_entries;
    logic              overflowed;
  } tally_t;

  int unsigned       win_base;
  logic [OFS_W-1:0]  prog_ofs  [TABLE_DEPTH];
  logic [STEP_W-1:0] prog_step [TABLE_DEPTH];
  int unsigned       prog_cnt;
  logic              dropped;
  bit                sieve [WINDOW];
  tally_t            expected_tallies [$];
  int unsigned       fail_cnt = 0;
  int unsigned       queued = 0;

  assign failures = fail_cnt;
  assign pending  = queued;

  // Knock out every member of one progression that lands in the window.
  function automatic void strike(int unsigned first, int unsigned stride);
    int unsigned e;
    if (stride == 0) begin
      if (first >= win_base && first - win_base < WINDOW) sieve[first - win_base] = 1'b0;
      return;
    end
    if (first >= win_base) e = first;
    else e = first + ((win_base - first + stride - 1) / stride) * stride;
    while (e - win_base < WINDOW) begin
      sieve[e - win_base] = 1'b0;
      e += stride;
    end
  endfunction

  function automatic tally_t count_survivors();
    int unsigned live;
    tally_t      t;
    live = 0;
    foreach (sieve[p]) sieve[p] = 1'b1;
    for (int i = 0; i < prog_cnt; i++) strike(prog_ofs[i], prog_step[i]);
    foreach (sieve[p]) live += sieve[p];
    t.survivors    = SURV_W'((live > SURV_MAX) ? SURV_MAX : live);
    t.used_entries = USED_W'((prog_cnt > USED_MAX) ? USED_MAX : prog_cnt);
    t.overflowed   = dropped;
    return t;
  endfunction

  function automatic int unsigned field_errors(tally_t want, tally_t got);
    int unsigned n;
    n = 0;
    if (got.survivors !== want.survivors) begin
      $error("survivors: expected %0d, got %0d", want.survivors, got.survivors);
      n++;
    end
    if (got.used_entries !== want.used_entries) begin
      $error("used_entries: expected %0d, got %0d", want.used_entries, got.used_entries);
      n++;
    end
    if (got.overflowed !== want.overflowed) begin
      $error("overflowed: expected %0d, got %0d", want.overflowed, got.overflowed);
      n++;
    end
    return n;
  endfunction

  always @(posedge clk) begin : watch
    int unsigned errs;
    tally_t      got;
    errs = 0;
    if (rst) begin
      win_base = 0;
      prog_cnt = 0;
      dropped  = 1'b0;
      expected_tallies.delete();
    end else begin
      if (cfg_we) win_base = cfg_wdata;
      // results first: a compute never answers in the cycle it is taken
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.survivors, out_ch.used_entries, out_ch.overflowed};
        if (expected_tallies.size() == 0) begin
          $error("unexpected result: survivors %0d, used_entries %0d, overflowed %0d",
                 got.survivors, got.used_entries, got.overflowed);
          errs++;
        end else begin
          errs += field_errors(expected_tallies.pop_front(), got);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        case (in_ch.mode)
          MODE_LOAD: begin
            if (prog_cnt < TABLE_DEPTH) begin
              prog_ofs[prog_cnt]  = in_ch.start_offset;
              prog_step[prog_cnt] = in_ch.step;
              prog_cnt++;
            end else begin
              dropped = 1'b1;
            end
          end
          MODE_COMPUTE: expected_tallies.push_back(count_survivors());
          MODE_CLEAR: begin
            prog_cnt = 0;
            dropped  = 1'b0;
          end
          default: ;
        endcase
      end
    end
    fail_cnt <= fail_cnt + errs;
    queued   <= expected_tallies.size();
  end

endmodule

[verif/tb.sv]
// Testbench top for sieve_window_survivor_count: clock, reset, transaction stimulus,
// window register writes and the verdict. Depends on swsc_pkg, swsc_in_if, swsc_out_if,
// the block itself and swsc_checker.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import swsc_pkg::*;

  localparam int CLK_PERIOD    = 10;
  localparam int RESET_CYCLES  = 9;
  // loads and clears retire without leaving the idle state; the settle time covers any still in flight
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 40;
  // must outlast two computes so the second result
  // finds the first still parked and the input stalls
  localparam int HOLD_CYCLES   = 60000;
  // worst compute here: ~32 progressions of step 1, each 10k hits, plus both sweeps
  localparam int STALL_LIMIT   = 1000000;
  localparam int ITEM_TARGET   = 600;
  localparam int RESULT_TARGET = 30;
  localparam int FILL_CAP      = 24;
  localparam int PROTH_BASE    = 0;
  localparam int STD_BASE      = 100000;
  localparam logic [1:0] MODE_NOP = 2'd3;   // unused mode code, block ignores it

  logic            clk = 1'b0;
  logic            rst;
  logic            cfg_we;
  logic [WS_W-1:0] cfg_wdata;
  int unsigned     failures;
  int unsigned     pending;

  // sender / receiver control
  bit          no_gaps   = 1'b0;
  bit          hold_req  = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned burst_left    = 0;
  int unsigned table_fill    = 0;   // loads since last clear, to bound compute time
  int unsigned items_sent    = 0;
  int unsigned computes_sent = 0;
  int unsigned idle_cycles   = 0;

  swsc_in_if  in_ch ();
  swsc_out_if out_ch ();

  sieve_window_survivor_count dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  swsc_checker tally_chk (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .failures  (failures),
    .pending   (pending)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Watchdog: any accepted transaction on either side resets the count.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result side: short stretches of always-ready, coin-flip, toggling or stalled,
  // plus one long hold-off when the stimulus asks for it.
  initial begin : result_drain
    int unsigned stretch;
    int unsigned pattern;
    out_ch.ready = 1'b0;
    forever begin
      if (hold_req && !hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        stretch = $urandom_range(1, 24);
        pattern = $urandom_range(0, 3);
        repeat (stretch) begin
          case (pattern)
            0:       out_ch.ready <= 1'b1;
            1:       out_ch.ready <= 1'($urandom_range(0, 1));
            2:       out_ch.ready <= ~out_ch.ready;
            default: out_ch.ready <= 1'b0;
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // Offer one transaction and return at the edge that accepts it. Bursts of random
  // length are separated by random gaps unless no_gaps is set. Called at a rising edge.
  task automatic send_txn(input logic [1:0] mode, input logic [OFS_W-1:0] ofs,
                          input logic [STEP_W-1:0] stp);
    if (burst_left == 0) begin
      if (!no_gaps) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    in_ch.valid        <= 1'b1;
    in_ch.mode         <= mode;
    in_ch.start_offset <= ofs;
    in_ch.step         <= stp;
    do @(posedge clk); while (!in_ch.ready);
    if (mode != MODE_NOP) items_sent++;
    if (mode == MODE_COMPUTE) computes_sent++;
  endtask

  task automatic send_load(input logic [OFS_W-1:0] ofs, input logic [STEP_W-1:0] stp);
    send_txn(MODE_LOAD, ofs, stp);
    table_fill++;
  endtask

  task automatic send_clear();
    send_txn(MODE_CLEAR, OFS_W'($urandom), STEP_W'($urandom));
    table_fill = 0;
  endtask

  task automatic send_compute();
    send_txn(MODE_COMPUTE, OFS_W'($urandom), STEP_W'($urandom));
  endtask

  // Stop offering, let every predicted result arrive (sampled mid-cycle, away from
  // the checker's updates), then give trailing loads time to retire.
  task automatic drain();
    in_ch.valid <= 1'b0;
    burst_left = 0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // window_start may only change while the block is idle
  task automatic set_window(input int unsigned base);
    drain();
    cfg_we    <= 1'b1;
    cfg_wdata <= WS_W'(base);
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic int unsigned pick_window();
    case ($urandom_range(0, 3))
      0:       return PROTH_BASE;
      1:       return STD_BASE;
      2:       return $urandom_range(0, STD_BASE);
      default: return $urandom_range(0, 600);   // straddles the start offsets
    endcase
  endfunction

  // One well-formed pass: optional clear, a handful of loads, then a compute.
  // Now and then an ignored mode or a stray clear breaks the pattern.
  task automatic run_sieve_pass();
    int unsigned n_loads;
    no_gaps = ($urandom_range(0, 3) == 0);
    if (table_fill > FILL_CAP || $urandom_range(0, 3) == 0) send_clear();
    n_loads = $urandom_range(0, 8);
    repeat (n_loads) begin
      case ($urandom_range(0, 19))
        0:       send_txn(MODE_NOP, OFS_W'($urandom), STEP_W'($urandom));
        1:       send_clear();
        default: send_load(OFS_W'($urandom), STEP_W'($urandom));
      endcase
    end
    send_compute();
  endtask

  // Fill the table past its depth so loads get dropped and the sticky flag rises,
  // then show that a clear brings both back. Large steps keep the walk short.
  task automatic run_overflow();
    send_clear();
    repeat (TABLE_DEPTH + 3) send_load(OFS_W'($urandom), STEP_W'($urandom_range(64, 511)));
    send_compute();
    send_load(OFS_W'($urandom), STEP_W'($urandom));
    send_compute();
    send_clear();
    send_compute();
  endtask

  // Receiver holds off for a long stretch while computes keep coming back to back:
  // the first result parks on the output and the block has to stall its input.
  task automatic run_backpressure();
    drain();
    hold_req = 1'b1;
    no_gaps  = 1'b1;
    send_clear();
    repeat (3) begin
      send_load(OFS_W'($urandom), STEP_W'($urandom_range(16, 511)));
      send_compute();
    end
    no_gaps = 1'b0;
  endtask

  initial begin : stimulus
    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_wdata          <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.mode         <= MODE_LOAD;
    in_ch.start_offset <= '0;
    in_ch.step         <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // --- directed, window_start at its reset value of 0 ---
    send_compute();                        // empty table: whole window survives
    send_load(8'd0, 9'd1);                 // step 1 from 0 wipes the window
    send_compute();
    send_clear();
    send_load(8'd255, 9'd0);               // step zero: only its start exponent
    send_load(8'd0, 9'd511);               // widest step
    send_load(8'hAA, 9'h0AA);
    send_load(8'h55, 9'h155);
    send_compute();
    send_txn(MODE_NOP, 8'hFF, 9'h1FF);     // ignored, no state change
    send_compute();

    // standard window: every progression starts below it
    set_window(STD_BASE);
    send_load(8'd7, 9'd13);
    send_compute();

    // window sits between the start offsets; step-zero entry at 255 lands inside it
    set_window(100);
    send_compute();
    send_clear();
    send_compute();

    // --- random passes, with window changes, one overflow run, one hold-off ---
    for (int unsigned pass_no = 0;
         items_sent < ITEM_TARGET || computes_sent < RESULT_TARGET; pass_no++) begin
      if (pass_no % 6 == 5) set_window(pick_window());
      if (pass_no == 4) run_backpressure();
      else if (pass_no == 9) run_overflow();
      else run_sieve_pass();
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (failures == 0 && pending == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

[sim.f]
rtl/swsc_pkg.sv
rtl/swsc_in_if.sv
rtl/swsc_out_if.sv
rtl/swsc_ctrl.sv
rtl/swsc_dpath.sv
rtl/sieve_window_survivor_count.sv
verif/swsc_checker.sv
verif/tb.sv
